// ===== rtl/core/tsgd_pkg.sv =====
package tsgd_pkg;

    localparam int NUM_PADS     = 5;
    localparam int READING_BITS = 10;
    localparam int PAD_W        = 3;
    localparam int LEVEL_W      = 8;
    localparam int TIME_W       = 32;
    localparam int CFG_ADDR_W   = 5;
    localparam int CFG_DATA_W   = 32;
    localparam int REG_INDEX_W  = 3;

    localparam logic [READING_BITS-1:0] THRESHOLD_RESET = 10'd17;
    localparam logic [LEVEL_W-1:0]      LEVEL_STEP      = 8'd47;
    localparam logic [LEVEL_W-1:0]      LEVEL_RESET     = 8'd94;
    localparam logic [PAD_W-1:0]        LAST_PAD_RESET  = 3'd4;
    localparam logic [PAD_W-1:0]        PAD_NONE        = 3'd0;
    localparam logic [TIME_W-1:0]       TAP_RELEASE_MS  = 32'd50;
    localparam logic [TIME_W-1:0]       TAP_HOLD_MS     = 32'd500;

    // operation codes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_HOST  = 1'b1;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_INDEX_W-1:0] REG_BASELINE_PAD1   = 3'd0;
    localparam logic [REG_INDEX_W-1:0] REG_BASELINE_PAD2   = 3'd1;
    localparam logic [REG_INDEX_W-1:0] REG_BASELINE_PAD3   = 3'd2;
    localparam logic [REG_INDEX_W-1:0] REG_BASELINE_PAD4   = 3'd3;
    localparam logic [REG_INDEX_W-1:0] REG_BASELINE_PAD5   = 3'd4;
    localparam logic [REG_INDEX_W-1:0] REG_TOUCH_THRESHOLD = 3'd5;

    typedef logic [NUM_PADS-1:0][READING_BITS-1:0] baseline_t;

    typedef struct packed {
        logic                    operation;
        logic [READING_BITS-1:0] reading_pad1;
        logic [READING_BITS-1:0] reading_pad2;
        logic [READING_BITS-1:0] reading_pad3;
        logic [READING_BITS-1:0] reading_pad4;
        logic [READING_BITS-1:0] reading_pad5;
        logic [TIME_W-1:0]       now_ms;
        logic                    host_power;
        logic [LEVEL_W-1:0]      host_brightness;
    } in_word_t;

    typedef struct packed {
        logic               power_state;
        logic [LEVEL_W-1:0] brightness_level;
        logic [PAD_W-1:0]   touched_pad;
        logic               tap_seen;
        logic               slide_seen;
    } out_word_t;

    function automatic logic [LEVEL_W-1:0] level_for_pad(input logic [PAD_W-1:0] pad);
        logic [LEVEL_W+PAD_W-1:0] prod;
        prod = (LEVEL_W+PAD_W)'(pad) * (LEVEL_W+PAD_W)'(LEVEL_STEP);
        return prod[LEVEL_W-1:0];
    endfunction

endpackage

// ===== rtl/core/tsgd_pad_select.sv =====
// Strongest pad over baseline; must strictly beat the threshold, ties to lower pad.
module tsgd_pad_select
(
    input  tsgd_pkg::in_word_t                     item,
    input  tsgd_pkg::baseline_t                    baseline,
    input  logic [tsgd_pkg::READING_BITS-1:0]      threshold,
    output logic [tsgd_pkg::PAD_W-1:0]             pad
);

    localparam int RISE_W = tsgd_pkg::READING_BITS + 1;

    logic [tsgd_pkg::NUM_PADS-1:0][tsgd_pkg::READING_BITS-1:0] reading;
    logic signed [RISE_W-1:0] rise [tsgd_pkg::NUM_PADS];
    logic signed [RISE_W-1:0] best;

    assign reading[0] = item.reading_pad1;
    assign reading[1] = item.reading_pad2;
    assign reading[2] = item.reading_pad3;
    assign reading[3] = item.reading_pad4;
    assign reading[4] = item.reading_pad5;

    always_comb
    begin
        for (int i = 0; i < tsgd_pkg::NUM_PADS; i++)
        begin
            rise[i] = $signed({1'b0, reading[i]}) - $signed({1'b0, baseline[i]});
        end
    end

    // five-step compare chain
    always_comb
    begin
        best = $signed({1'b0, threshold});
        pad  = tsgd_pkg::PAD_NONE;
        for (int i = 0; i < tsgd_pkg::NUM_PADS; i++)
        begin
            if (rise[i] > best)
            begin
                best = rise[i];
                pad  = tsgd_pkg::PAD_W'(i + 1);
            end
        end
    end

endmodule

// ===== rtl/core/tsgd_history.sv =====
// Ring of past pads with a running sum; flags a rounded mean of zero.
module tsgd_history
#(
    parameter int HISTORY_DEPTH = 70
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [tsgd_pkg::PAD_W-1:0]  prev,
    output logic                        mean_zero
);

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W = $clog2(5 * HISTORY_DEPTH + 1);

    logic [tsgd_pkg::PAD_W-1:0] mem [HISTORY_DEPTH];
    logic [tsgd_pkg::PAD_W-1:0] head_reg;
    logic [tsgd_pkg::PAD_W-1:0] head;
    logic [PTR_W-1:0]           ptr_reg;
    logic [PTR_W-1:0]           ptr_next;
    logic                       wrapped_reg;
    logic                       wrapped_next;
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           sum_next;

    // entries are written in ring order, so the oldest one is real only after a wrap
    assign head         = wrapped_reg ? head_reg : '0;
    assign ptr_next     = (ptr_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign wrapped_next = wrapped_reg | (ptr_reg == PTR_W'(HISTORY_DEPTH - 1));
    assign sum_next     = sum_reg - SUM_W'(head) + SUM_W'(prev);
    assign mean_zero    = {sum_next, 1'b0} < (SUM_W + 1)'(HISTORY_DEPTH);

    // write the new entry, prefetch the next oldest one
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            mem[ptr_reg] <= prev;
            head_reg     <= (ptr_next == ptr_reg) ? prev : mem[ptr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            wrapped_reg <= 1'b0;
            sum_reg     <= '0;
        end
        else if (step)
        begin
            ptr_reg     <= ptr_next;
            wrapped_reg <= wrapped_next;
            sum_reg     <= sum_next;
        end
    end

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg < PTR_W'(HISTORY_DEPTH))
        else $error("history pointer out of range");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_W'(5 * HISTORY_DEPTH))
        else $error("history sum exceeds bound");

    a_sum_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !wrapped_reg |-> sum_reg <= SUM_W'(5) * SUM_W'(ptr_reg))
        else $error("history sum larger than entries written");

endmodule

// ===== rtl/core/tsgd_gesture.sv =====
// Slide / tap recognition and lamp state.
module tsgd_gesture
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        frame_step,
    input  logic                        host_step,
    input  tsgd_pkg::in_word_t          item,
    input  logic [tsgd_pkg::PAD_W-1:0]  pad,
    input  logic                        mean_zero,
    output logic [tsgd_pkg::PAD_W-1:0]  prev,
    output tsgd_pkg::out_word_t         result
);

    logic [tsgd_pkg::PAD_W-1:0]   last_pad_reg;
    logic                         tap_pending_reg;
    logic [tsgd_pkg::TIME_W-1:0]  tap_start_reg;
    logic                         lamp_on_reg;
    logic [tsgd_pkg::LEVEL_W-1:0] lamp_level_reg;

    logic                         slide;
    logic                         start;
    logic                         pending;
    logic                         tap;
    logic                         tap_pending_next;
    logic [tsgd_pkg::TIME_W-1:0]  tap_start_next;
    logic [tsgd_pkg::TIME_W-1:0]  elapsed;
    logic                         lamp_on_next;
    logic [tsgd_pkg::LEVEL_W-1:0] lamp_level_next;

    assign prev = last_pad_reg;

    assign slide = (last_pad_reg != tsgd_pkg::PAD_NONE) && (pad != tsgd_pkg::PAD_NONE)
                   && (last_pad_reg != pad);
    assign start = mean_zero && (pad != tsgd_pkg::PAD_NONE);

    // slide cancels a running timer; a fresh touch may restart it
    assign pending        = start | (tap_pending_reg & ~slide);
    assign tap_start_next = start ? item.now_ms : tap_start_reg;
    assign elapsed        = item.now_ms - tap_start_next;

    assign tap = pending
                 && (((pad == tsgd_pkg::PAD_NONE) && (elapsed > tsgd_pkg::TAP_RELEASE_MS))
                     || (elapsed > tsgd_pkg::TAP_HOLD_MS));
    assign tap_pending_next = pending & ~tap;

    assign lamp_on_next    = tap ? ~lamp_on_reg : (slide | lamp_on_reg);
    assign lamp_level_next = slide ? tsgd_pkg::level_for_pad(pad) : lamp_level_reg;

    always_comb
    begin
        if (item.operation == tsgd_pkg::OP_HOST)
        begin
            result.power_state      = item.host_power;
            result.brightness_level = item.host_brightness;
            result.touched_pad      = tsgd_pkg::PAD_NONE;
            result.tap_seen         = 1'b0;
            result.slide_seen       = 1'b0;
        end
        else
        begin
            result.power_state      = lamp_on_next;
            result.brightness_level = lamp_level_next;
            result.touched_pad      = pad;
            result.tap_seen         = tap;
            result.slide_seen       = slide;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pad_reg    <= tsgd_pkg::LAST_PAD_RESET;
            tap_pending_reg <= 1'b0;
            tap_start_reg   <= '0;
            lamp_on_reg     <= 1'b1;
            lamp_level_reg  <= tsgd_pkg::LEVEL_RESET;
        end
        else if (frame_step)
        begin
            last_pad_reg    <= pad;
            tap_pending_reg <= tap_pending_next;
            tap_start_reg   <= tap_start_next;
            lamp_on_reg     <= lamp_on_next;
            lamp_level_reg  <= lamp_level_next;
        end
        else if (host_step)
        begin
            lamp_on_reg     <= item.host_power;
            lamp_level_reg  <= item.host_brightness;
        end
    end

endmodule

// ===== rtl/core/touch_strip_gesture_detector.sv =====
// Touch strip gesture detector. Each input word is either a sensor frame (five
// pad readings plus a millisecond time) or a host write of lamp power and
// brightness; every word yields exactly one result word carrying the lamp state
// after it, the pad touched on that frame and tap/slide flags. A word is latched
// in an input register, processed in a single pass of short logic (baseline
// subtract and five-way compare, history ring update with a running sum, tap
// timer) and lands in an output register, so the block sustains one word per
// clock while the output is not stalled: out_valid rises once the result is
// registered in the output register, and a new word is taken every cycle
// unless the output register is full and stalled. The pad history ring is a
// HISTORY_DEPTH-entry memory read one entry ahead of the write pointer; it
// needs no clearing pass after reset. Baselines and threshold are written over
// the APB port at byte address 4*index and should be changed only while no
// word is in flight.
module touch_strip_gesture_detector
#(
    parameter int HISTORY_DEPTH = 70
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  tsgd_pkg::in_word_t                in_word,

    output logic                              out_valid,
    input  logic                              out_ready,
    output tsgd_pkg::out_word_t               out_word,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tsgd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tsgd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tsgd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    tsgd_pkg::baseline_t                   baseline_reg;
    logic [tsgd_pkg::READING_BITS-1:0]     threshold_reg;
    logic [tsgd_pkg::REG_INDEX_W-1:0]      reg_index;
    logic                                  cfg_write;

    assign pready    = 1'b1;
    assign reg_index = paddr[tsgd_pkg::CFG_ADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg  <= '0;
            threshold_reg <= tsgd_pkg::THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index) inside
                tsgd_pkg::REG_BASELINE_PAD1, tsgd_pkg::REG_BASELINE_PAD2,
                tsgd_pkg::REG_BASELINE_PAD3, tsgd_pkg::REG_BASELINE_PAD4,
                tsgd_pkg::REG_BASELINE_PAD5:
                    baseline_reg[reg_index] <= pwdata[tsgd_pkg::READING_BITS-1:0];
                tsgd_pkg::REG_TOUCH_THRESHOLD:
                    threshold_reg <= pwdata[tsgd_pkg::READING_BITS-1:0];
                default:
                    ; // unmapped: write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index) inside
            tsgd_pkg::REG_BASELINE_PAD1, tsgd_pkg::REG_BASELINE_PAD2,
            tsgd_pkg::REG_BASELINE_PAD3, tsgd_pkg::REG_BASELINE_PAD4,
            tsgd_pkg::REG_BASELINE_PAD5:
                prdata = tsgd_pkg::CFG_DATA_W'(baseline_reg[reg_index]);
            tsgd_pkg::REG_TOUCH_THRESHOLD:
                prdata = tsgd_pkg::CFG_DATA_W'(threshold_reg);
            default:
                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // input register -> single-pass logic -> output register
    // ---------------------------------------------------------------
    tsgd_pkg::in_word_t   in_word_reg;
    logic                 in_valid_reg;
    tsgd_pkg::out_word_t  out_word_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 frame_step;
    logic                 host_step;

    // the input stage moves on whenever the output register is free or draining
    assign advance    = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready   = ~in_valid_reg | advance;
    assign frame_step = advance & (in_word_reg.operation == tsgd_pkg::OP_FRAME);
    assign host_step  = advance & (in_word_reg.operation == tsgd_pkg::OP_HOST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_word;
        end
    end

    logic [tsgd_pkg::PAD_W-1:0] pad;
    logic [tsgd_pkg::PAD_W-1:0] prev;
    logic                       mean_zero;
    tsgd_pkg::out_word_t        result;

    tsgd_pad_select u_pad_select
    (
        .item      (in_word_reg),
        .baseline  (baseline_reg),
        .threshold (threshold_reg),
        .pad       (pad)
    );

    tsgd_history
    #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    )
    u_history
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (frame_step),
        .prev      (prev),
        .mean_zero (mean_zero)
    );

    tsgd_gesture u_gesture
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_step (frame_step),
        .host_step  (host_step),
        .item       (in_word_reg),
        .pad        (pad),
        .mean_zero  (mean_zero),
        .prev       (prev),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while both stages are full");

    a_host_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
        host_step |=> (out_word.touched_pad == tsgd_pkg::PAD_NONE)
                      && !out_word.tap_seen && !out_word.slide_seen)
        else $error("host write result carries gesture fields");

    a_slide_powers_on: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.slide_seen && !out_word.tap_seen)
            |-> out_word.power_state && (out_word.touched_pad != tsgd_pkg::PAD_NONE))
        else $error("slide without touched pad or power");

endmodule

// ===== sim/touch_strip_gesture_detector_test.sv =====
`timescale 1ns / 100ps

module touch_strip_gesture_detector_test;
    import tsgd_pkg::*;

    // ------------------------------------------------------------------
    // Run parameters
    // ------------------------------------------------------------------
    localparam int HIST_DEPTH  = 70;
    localparam int CLK_HALF    = 6;           // 12 ns period
    localparam int RESET_LEN   = 10;
    localparam int IDLE_LIMIT  = 5000;        // cycles without any transfer
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 8;           // pipeline is two deep
    localparam int STALL_LEN   = 400;         // long receiver hold-off
    localparam int STALL_AT    = 500;         // results seen before the hold-off
    localparam int NUM_PHASES  = 6;
    localparam int READ_MAX    = (1 << READING_BITS) - 1;

    // ------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_word_t              in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_word;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    touch_strip_gesture_detector #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word (out_word),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Lamp predictor state: our own copy of config and gesture state
    // ------------------------------------------------------------------
    logic [READING_BITS-1:0] base_cfg [NUM_PADS];
    logic [READING_BITS-1:0] thr_cfg;
    logic [PAD_W-1:0]        pad_prev;
    logic [PAD_W-1:0]        pad_ring [HIST_DEPTH];
    int                      ring_ptr;
    int                      ring_sum;
    logic                    timer_armed;     // valid flag for timer_t0
    logic [TIME_W-1:0]       timer_t0;
    logic                    lamp_pwr;
    logic [LEVEL_W-1:0]      lamp_lvl;

    out_word_t lamp_expected [$];             // lamp words still to come out

    // counters
    int words_sent   = 0;
    int results_seen = 0;
    int taps_seen    = 0;
    int slides_seen  = 0;
    int fail_count   = 0;
    int idle_cycles  = 0;
    int burst_left   = 0;

    logic [TIME_W-1:0] clock_ms = '0;         // sensor time for generated frames

    // directed table row: either a register write or a word
    typedef struct {
        bit                      is_cfg;
        int                      cfg_index;
        logic [READING_BITS-1:0] cfg_value;
        in_word_t                word;
        bit                      has_exp;
        out_word_t               exp;
    } step_t;

    step_t directed_steps [$];

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Predictor: one lamp word per accepted input word
    // ------------------------------------------------------------------
    function automatic out_word_t predict_lamp(input in_word_t w);
        out_word_t               res;
        logic [READING_BITS-1:0] rd [NUM_PADS];
        logic [PAD_W-1:0]        pad;
        logic [PAD_W-1:0]        prev;
        logic [TIME_W-1:0]       elapsed;
        int                      best;
        int                      rise;
        logic                    tap;
        logic                    slide;
        res = '0;
        // host write: lamp state only, gesture state untouched
        if (w.operation == OP_HOST)
        begin
            lamp_pwr = w.host_power;
            lamp_lvl = w.host_brightness;
            res.power_state      = lamp_pwr;
            res.brightness_level = lamp_lvl;
            return res;
        end
        rd[0] = w.reading_pad1;
        rd[1] = w.reading_pad2;
        rd[2] = w.reading_pad3;
        rd[3] = w.reading_pad4;
        rd[4] = w.reading_pad5;
        // previous pad goes into the ring, running sum follows
        prev = pad_prev;
        ring_sum = ring_sum - int'(pad_ring[ring_ptr]) + int'(prev);
        pad_ring[ring_ptr] = prev;
        ring_ptr = (ring_ptr + 1) % HIST_DEPTH;
        // signed rise, strict compare, lower pad wins a tie
        best = int'(thr_cfg);
        pad  = PAD_NONE;
        for (int i = 0; i < NUM_PADS; i++)
        begin
            rise = int'(rd[i]) - int'(base_cfg[i]);
            if (rise > best)
            begin
                best = rise;
                pad  = PAD_W'(i + 1);
            end
        end
        pad_prev = pad;
        tap   = 1'b0;
        slide = 1'b0;
        if (prev != PAD_NONE && pad != PAD_NONE && prev != pad)
        begin
            slide       = 1'b1;
            timer_armed = 1'b0;
        end
        // rounded history mean is zero
        if (2 * ring_sum < HIST_DEPTH && pad != PAD_NONE)
        begin
            timer_t0    = w.now_ms;
            timer_armed = 1'b1;
        end
        elapsed = w.now_ms - timer_t0;
        if (timer_armed && ((pad == PAD_NONE && elapsed > TAP_RELEASE_MS) ||
                            elapsed > TAP_HOLD_MS))
        begin
            tap         = 1'b1;
            timer_armed = 1'b0;
        end
        if (tap && lamp_pwr)
            lamp_pwr = 1'b0;
        else if ((tap || slide) && !lamp_pwr)
            lamp_pwr = 1'b1;
        if (slide)
            lamp_lvl = LEVEL_W'(int'(pad) * int'(LEVEL_STEP));
        res.power_state      = lamp_pwr;
        res.brightness_level = lamp_lvl;
        res.touched_pad      = pad;
        res.tap_seen         = tap;
        res.slide_seen       = slide;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------
    function automatic in_word_t make_host(input logic pwr, input logic [LEVEL_W-1:0] lvl);
        in_word_t w;
        w = '0;
        w.operation       = OP_HOST;
        w.reading_pad1    = READING_BITS'($urandom);
        w.reading_pad3    = READING_BITS'($urandom);
        w.now_ms          = $urandom;
        w.host_power      = pwr;
        w.host_brightness = lvl;
        return w;
    endfunction

    function automatic in_word_t dir_frame(input int r1, input int r2, input int r3,
                                           input int r4, input int r5,
                                           input logic [TIME_W-1:0] t);
        in_word_t w;
        w = '0;
        w.operation    = OP_FRAME;
        w.reading_pad1 = READING_BITS'(r1);
        w.reading_pad2 = READING_BITS'(r2);
        w.reading_pad3 = READING_BITS'(r3);
        w.reading_pad4 = READING_BITS'(r4);
        w.reading_pad5 = READING_BITS'(r5);
        w.now_ms       = t;
        return w;
    endfunction

    // Frame touching one pad (0 none) against the current config; twin gets
    // the same rise to provoke a tie.
    function automatic in_word_t make_frame(input int pad, input int twin);
        int v [NUM_PADS];
        int top;
        for (int i = 0; i < NUM_PADS; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                v[i] = int'(base_cfg[i]) - int'($urandom_range(0, 40));
            else
                v[i] = int'(base_cfg[i]) + int'($urandom_range(0, thr_cfg));
        end
        if (pad != 0)
        begin
            top = int'(base_cfg[pad-1]) + int'(thr_cfg) + 1 + int'($urandom_range(0, 150));
            v[pad-1] = top;
            if (twin != 0)
                v[twin-1] = top - int'(base_cfg[pad-1]) + int'(base_cfg[twin-1]);
        end
        for (int i = 0; i < NUM_PADS; i++)
        begin
            if (v[i] < 0)
                v[i] = 0;
            else if (v[i] > READ_MAX)
                v[i] = READ_MAX;
        end
        make_frame = dir_frame(v[0], v[1], v[2], v[3], v[4], clock_ms);
        make_frame.host_power      = 1'($urandom);
        make_frame.host_brightness = LEVEL_W'($urandom);
    endfunction

    function automatic out_word_t mk_out(input logic pwr, input logic [LEVEL_W-1:0] lvl,
                                         input logic [PAD_W-1:0] pad,
                                         input logic tap, input logic slide);
        out_word_t o;
        o.power_state      = pwr;
        o.brightness_level = lvl;
        o.touched_pad      = pad;
        o.tap_seen         = tap;
        o.slide_seen       = slide;
        return o;
    endfunction

    function automatic void add_word(input in_word_t w);
        step_t s;
        s = '{is_cfg: 1'b0, cfg_index: 0, cfg_value: '0, word: w, has_exp: 1'b0, exp: '0};
        directed_steps = {directed_steps, s};
    endfunction

    function automatic void add_cfg(input int idx, input int val);
        step_t s;
        s = '{is_cfg: 1'b1, cfg_index: idx, cfg_value: READING_BITS'(val), word: '0,
              has_exp: 1'b0, exp: '0};
        directed_steps = {directed_steps, s};
    endfunction

    function automatic void expect_last(input out_word_t e);
        directed_steps[directed_steps.size()-1].has_exp = 1'b1;
        directed_steps[directed_steps.size()-1].exp     = e;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one word, hold it until taken, then queue what it should produce.
    // A typed expectation replaces the prediction but the predictor still steps.
    task automatic offer_word(input in_word_t w, input bit use_typed, input out_word_t typed);
        out_word_t predicted;
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        predicted = predict_lamp(w);
        if (use_typed)
            predicted = typed;
        lamp_expected = {lamp_expected, predicted};
        words_sent++;
    endtask

    task automatic pause_sender(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // bursts of random length, gaps in between (some bursts run back to back)
    task automatic feed_word(input in_word_t w, input bit use_typed, input out_word_t typed);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
        end
        burst_left--;
        offer_word(w, use_typed, typed);
    endtask

    task automatic send_frame(input int pad, input int twin);
        feed_word(make_frame(pad, twin), 1'b0, '0);
        if ($urandom_range(0, 49) == 0)
            clock_ms += $urandom_range(100, 5000);
        else
            clock_ms += $urandom_range(5, 40);
    endtask

    // stop offering until every queued lamp word is out, then let it settle
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (lamp_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // APB register write, read back for mapped indexes; upper data bits carry junk
    // ------------------------------------------------------------------
    task automatic cfg_set(input int idx, input logic [READING_BITS-1:0] val);
        logic [CFG_DATA_W-1:0] data;
        data = $urandom;
        data[READING_BITS-1:0] = val;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx > int'(REG_TOUCH_THRESHOLD))
            return;                               // unused index, nothing to track
        if (idx == int'(REG_TOUCH_THRESHOLD))
            thr_cfg = val;
        else
            base_cfg[idx] = val;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[READING_BITS-1:0] !== val)
            note_failure($sformatf("register %0d reads %0h, expected %0h",
                                   idx, prdata[READING_BITS-1:0], val));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random gestures: mostly well-formed touch sequences, some noise
    // ------------------------------------------------------------------
    task automatic run_gesture();
        int                kind;
        int                n;
        int                p;
        int                q;
        int                span;
        logic [TIME_W-1:0] t_start;
        logic [95:0]       raw;
        in_word_t          w;
        kind = $urandom_range(0, 99);
        p    = $urandom_range(1, NUM_PADS);
        if (kind < 28)
        begin
            // quiet stretch, pulls the history mean back to zero
            repeat ($urandom_range(1, 75)) send_frame(0, 0);
        end
        else if (kind < 53 || (kind >= 73 && kind < 83))
        begin
            // short touch (tap on release) or long hold past the hold limit
            span    = (kind < 53) ? $urandom_range(10, 450) : $urandom_range(480, 800);
            t_start = clock_ms;
            do send_frame(p, 0); while ((clock_ms - t_start) < TIME_W'(span));
            send_frame(0, 0);
        end
        else if (kind < 73)
        begin
            // slide across two to four pads
            n = $urandom_range(2, 4);
            repeat (n)
            begin
                repeat ($urandom_range(1, 4)) send_frame(p, 0);
                q = $urandom_range(1, NUM_PADS - 1);
                p = (p - 1 + q) % NUM_PADS + 1;
            end
            send_frame(0, 0);
        end
        else if (kind < 88)
        begin
            feed_word(make_host(1'($urandom), LEVEL_W'($urandom)), 1'b0, '0);
        end
        else if (kind < 93)
        begin
            // two pads with the same rise
            p = $urandom_range(1, NUM_PADS - 1);
            q = $urandom_range(p + 1, NUM_PADS);
            repeat ($urandom_range(1, 6)) send_frame(p, q);
            send_frame(0, 0);
        end
        else
        begin
            // fully random words, random times now and then
            repeat ($urandom_range(1, 5))
            begin
                raw = {$urandom, $urandom, $urandom};
                w   = raw[$bits(in_word_t)-1:0];
                if ($urandom_range(0, 3) != 0)
                    w.now_ms = clock_ms;
                feed_word(w, 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int mode;
        int run;
        bit held_once;
        held_once = 1'b0;
        forever
        begin
            if (!held_once && results_seen >= STALL_AT)
            begin
                held_once = 1'b1;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (STALL_LEN - 1) @(negedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                run  = $urandom_range(1, 60);
                repeat (run)
                begin
                    @(negedge clk);
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom_range(0, 1));
                        2:       out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= ~out_ready;
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each taken word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : lamp_checker
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (lamp_expected.size() == 0)
                note_failure($sformatf("unexpected word pwr=%0d lvl=%0d pad=%0d tap=%0d slide=%0d",
                                       out_word.power_state, out_word.brightness_level,
                                       out_word.touched_pad, out_word.tap_seen,
                                       out_word.slide_seen));
            else
            begin
                want = lamp_expected[0];
                lamp_expected.delete(0);
                if (want.tap_seen)
                    taps_seen++;
                if (want.slide_seen)
                    slides_seen++;
                if (out_word.power_state      !== want.power_state      ||
                    out_word.brightness_level !== want.brightness_level ||
                    out_word.touched_pad      !== want.touched_pad      ||
                    out_word.tap_seen         !== want.tap_seen         ||
                    out_word.slide_seen       !== want.slide_seen)
                    note_failure($sformatf(
                        "pwr/lvl/pad/tap/slide exp %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                        want.power_state, want.brightness_level, want.touched_pad,
                        want.tap_seen, want.slide_seen,
                        out_word.power_state, out_word.brightness_level, out_word.touched_pad,
                        out_word.tap_seen, out_word.slide_seen));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no transfer on any port ends the run
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int                      bv;
        int                      tv;
        int                      budget;
        int                      goal;
        bit                      drained_mid;
        // predictor reset state
        for (int i = 0; i < NUM_PADS; i++)
            base_cfg[i] = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
            pad_ring[i] = PAD_NONE;
        thr_cfg     = THRESHOLD_RESET;
        pad_prev    = LAST_PAD_RESET;
        ring_ptr    = 0;
        ring_sum    = 0;
        timer_armed = 1'b0;
        timer_t0    = '0;
        lamp_pwr    = 1'b1;
        lamp_lvl    = LEVEL_RESET;
        drained_mid = 1'b0;

        // directed table, reset config first
        add_word(dir_frame(0, 0, 0, 0, 0, 32'd0));                 // state after reset
        expect_last(mk_out(1'b1, LEVEL_RESET, PAD_NONE, 1'b0, 1'b0));
        add_word(make_host(1'b0, 8'd255));                          // host extremes
        expect_last(mk_out(1'b0, 8'd255, PAD_NONE, 1'b0, 1'b0));
        add_word(make_host(1'b1, 8'd0));
        expect_last(mk_out(1'b1, 8'd0, PAD_NONE, 1'b0, 1'b0));
        add_word(dir_frame(READ_MAX, READ_MAX, READ_MAX, READ_MAX, READ_MAX, 32'd1000));
        expect_last(mk_out(1'b1, 8'd0, 3'd1, 1'b0, 1'b0));         // five-way tie
        add_word(dir_frame(0, READ_MAX, 0, 0, 0, 32'd1010));       // slide, timer restarts
        add_word(dir_frame(0, 0, 0, 0, 0, 32'd1100));              // release tap, power off
        add_word(dir_frame(0, 0, 17, 0, 0, 32'd1200));             // rise equals threshold
        add_word(dir_frame(0, 0, 18, 0, 0, 32'd1210));             // one above
        add_word(make_host(1'b0, 8'd200));                          // host write mid-timer
        add_word(dir_frame(0, 0, 0, 0, 0, 32'd1300));              // tap while off
        add_word(dir_frame(0, 0, 0, 500, 500, 32'd2000));          // tie pads 4 and 5
        add_word(dir_frame(0, 0, 0, 600, 0, 32'd2400));
        add_word(dir_frame(0, 0, 0, 600, 0, 32'd2501));
        add_word(dir_frame(0, 0, 0, 0, 0, 32'd2510));
        add_word(dir_frame(0, 0, 0, 0, 100, 32'hFFFF_FFF0));       // timer across the wrap
        add_word(dir_frame(0, 0, 0, 0, 0, 32'h0000_0030));
        add_word(dir_frame(0, 300, 0, 0, 0, 32'd0));               // timer started at time zero
        add_word(dir_frame(0, 0, 0, 0, 0, 32'd51));
        add_word(dir_frame(READ_MAX, 0, 0, 0, 0, 32'd100));
        add_word(dir_frame(0, 0, 0, 0, READ_MAX, 32'd110));        // slide to top pad
        for (int i = 0; i < NUM_PADS; i++)
            add_cfg(int'(REG_BASELINE_PAD1) + i, READ_MAX);
        add_cfg(int'(REG_TOUCH_THRESHOLD), 0);
        add_cfg(int'(REG_TOUCH_THRESHOLD) + 1, 0);                 // unused indexes
        add_cfg(int'(REG_TOUCH_THRESHOLD) + 2, READ_MAX);
        add_word(dir_frame(0, 0, 0, 0, 0, 32'd200));               // rises all negative
        add_word(dir_frame(READ_MAX, READ_MAX, READ_MAX, READ_MAX, READ_MAX, 32'd210));
        for (int i = 0; i < NUM_PADS; i++)
            add_cfg(int'(REG_BASELINE_PAD1) + i, 0);
        add_cfg(int'(REG_TOUCH_THRESHOLD), READ_MAX);
        add_word(dir_frame(READ_MAX, READ_MAX, READ_MAX, READ_MAX, READ_MAX, 32'd220));

        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[k])
        begin
            if (directed_steps[k].is_cfg)
            begin
                wait_results_drained();
                cfg_set(directed_steps[k].cfg_index, directed_steps[k].cfg_value);
            end
            else
                feed_word(directed_steps[k].word, directed_steps[k].has_exp,
                          directed_steps[k].exp);
        end

        // random phases, one config setting each; extremes get shorter runs
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_results_drained();
            for (int i = 0; i < NUM_PADS; i++)
            begin
                case (ph)
                    0:       bv = $urandom_range(0, 400);
                    1:       bv = (i % 2 == 0) ? 0 : READ_MAX;
                    2, 4:    bv = 0;
                    3:       bv = $urandom_range(0, READ_MAX);
                    default: bv = $urandom_range(0, 120);
                endcase
                cfg_set(int'(REG_BASELINE_PAD1) + i, READING_BITS'(bv));
            end
            case (ph)
                0:       tv = $urandom_range(10, 80);
                1:       tv = 0;
                2:       tv = READ_MAX;
                3:       tv = $urandom_range(0, READ_MAX);
                4:       tv = int'(THRESHOLD_RESET);
                default: tv = $urandom_range(0, 200);
            endcase
            cfg_set(int'(REG_TOUCH_THRESHOLD), READING_BITS'(tv));
            if (ph == 4)
                clock_ms = 32'hFFFF_F000;        // run across the time wrap
            else if (ph == 3)
                clock_ms = $urandom;
            budget = (ph == 1 || ph == 2) ? 120 : 340;
            goal   = words_sent + budget;
            while (words_sent < goal)
            begin
                run_gesture();
                // once: sender waits for every lamp word before going on
                if (ph == 3 && !drained_mid && words_sent >= goal - budget / 2)
                begin
                    drained_mid = 1'b1;
                    wait_results_drained();
                end
            end
        end

        wait_results_drained();
        $display("Checked %0d lamp words from %0d input words (%0d taps, %0d slides).",
                 results_seen, words_sent, taps_seen, slides_seen);
        $display("Six register settings incl. extremes, a long output stall, a mid-run drain.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
